// ----- rtl/cdhs_pkg.sv -----
`timescale 1ns / 1ps

package cdhs_pkg;

    // Input word layout, lowest bit first
    localparam int MAIN_V_W  = 10;
    localparam int AUX_V_W   = 10;
    localparam int MACH_W    = 9;
    localparam int TICK_W    = 16;
    localparam int SEC_W     = 9;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    localparam logic [MAIN_V_W-1:0] POWER_MIN_DV  = 10'd180;
    localparam logic [MACH_W-1:0]   MACH_MAX_H    = 9'd125;
    localparam logic [SEC_W-1:0]    CYCLE_END_SEC = 9'd480;
    localparam logic [TICK_W-1:0]   LIMIT_RESET   = 16'd20;

    typedef enum logic [1:0] {
        PROG_NONE = 2'd0,
        PROG_PZ1  = 2'd1,
        PROG_PZ2  = 2'd2,
        PROG_PZ3  = 2'd3
    } prog_t;

    // Heater section flags: a = F110, b = F19, c = F125, d = F134
    typedef struct packed {
        logic d;
        logic c;
        logic b;
        logic a;
    } heater_t;

endpackage

// ----- rtl/cdhs_windows.sv -----
`timescale 1ns / 1ps

// Second-window decode of the three heater programs.
module cdhs_windows (
    input  cdhs_pkg::prog_t               prog,
    input  logic [cdhs_pkg::SEC_W-1:0]    sec,
    output cdhs_pkg::heater_t             heat
);
    import cdhs_pkg::*;

    function automatic logic in_win(input logic [SEC_W-1:0] s,
                                    input logic [SEC_W-1:0] lo,
                                    input logic [SEC_W-1:0] hi);
        return (s >= lo) && (s < hi);
    endfunction

    logic a_pz12;

    // PZ1 and PZ2 share the F110 pattern
    assign a_pz12 = (sec < 9'd20) || in_win(sec, 9'd120, 9'd140)
                 || in_win(sec, 9'd240, 9'd260) || in_win(sec, 9'd360, 9'd380);

    always_comb begin
        heat = '0;
        unique case (prog)
            PROG_NONE: begin
                heat = '0;
            end
            PROG_PZ1: begin
                heat.a = a_pz12;
                // PZ1 has no F19 section; its windows are open at both ends
                heat.c = (sec > 9'd400) && (sec < 9'd420);
                heat.d = ((sec > 9'd160) && (sec < 9'd180))
                      || ((sec > 9'd440) && (sec < 9'd460));
            end
            PROG_PZ2: begin
                heat.a = a_pz12;
                heat.b = in_win(sec, 9'd40, 9'd60) || in_win(sec, 9'd280, 9'd300);
                heat.c = in_win(sec, 9'd160, 9'd180) || in_win(sec, 9'd400, 9'd420);
                heat.d = in_win(sec, 9'd440, 9'd460);
            end
            PROG_PZ3: begin
                heat.a = (sec < 9'd60) || in_win(sec, 9'd240, 9'd300);
                heat.b = in_win(sec, 9'd120, 9'd180) || in_win(sec, 9'd360, 9'd420);
                heat.c = in_win(sec, 9'd180, 9'd240) || in_win(sec, 9'd420, 9'd480);
                heat.d = in_win(sec, 9'd300, 9'd360);
            end
            default: begin
                heat = '0;
            end
        endcase
    end

endmodule

// ----- rtl/cyclic_deicing_heater_sequencer.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// s_        in   s_tvalid / s_tready    s_tdata: one tick word (switches, buses, Mach)
// m_        out  m_tvalid / m_tready    m_tdata: relay and heater word, one per tick
// cfg_      in   cfg_valid / cfg_ready  cfg_data: ticks_per_second_limit
//
// Two register stages: input word register, then result register. Tick
// logic (relays, counters, window decode) sits between them, and one word
// is taken every cycle while m_ is not stalled. Counter state advances when
// a word moves from the input register to the result register. Stalls on
// m_ ripple back to s_tready through the stage enables. aresetn (sync, low)
// empties both stages, clears the counters and loads the limit with 20.
module cyclic_deicing_heater_sequencer (
    input  logic                               aclk,
    input  logic                               aresetn,
    // [9:0] main_bus_decivolts, [19:10] aux_bus_decivolts,
    // [28:20] mach_hundredths, [29] test_switch_on, [30] external_relay_on,
    // [31] intake_failure, [33:32] range_select, [39:34] zero
    input  logic [cdhs_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] heat_enable, [1] test_relay, [2] block_relay, [4:3] active_program,
    // [5] heater_a, [6] heater_b, [7] heater_c, [8] heater_d, [15:9] zero
    output logic [cdhs_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [cdhs_pkg::TICK_W-1:0]        cfg_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready
);
    import cdhs_pkg::*;

    // Stage handshake
    logic                   in_valid_reg;
    logic [S_TDATA_W-1:0]   in_data_reg;
    logic                   out_valid_reg;
    logic [M_TDATA_W-1:0]   out_data_reg;
    logic                   advance;

    // Config and counter state
    logic [TICK_W-1:0]      limit_reg;
    logic [TICK_W-1:0]      tick_reg, tick_next;
    logic [SEC_W-1:0]       sec_reg, sec_next;
    prog_t                  last_prog_reg, last_prog_next;

    // Unpacked fields of the held word
    logic [MAIN_V_W-1:0]    main_v;
    logic [AUX_V_W-1:0]     aux_v;
    logic [MACH_W-1:0]      mach;
    logic                   test_sw;
    logic                   ext_relay;
    logic                   fail;
    logic [1:0]             sel;

    logic                   main_ok;
    logic                   f12, k51, k2;
    prog_t                  prog;
    logic                   restart;
    logic [TICK_W-1:0]      tick_base, tick_inc, tick_step;
    logic [SEC_W-1:0]       sec_base, sec_step;
    logic                   roll;
    logic                   cycle_wrap;
    heater_t                heat;
    logic [M_TDATA_W-1:0]   out_data_next;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign main_v    = in_data_reg[9:0];
    assign aux_v     = in_data_reg[19:10];
    assign mach      = in_data_reg[28:20];
    assign test_sw   = in_data_reg[29];
    assign ext_relay = in_data_reg[30];
    assign fail      = in_data_reg[31];
    assign sel       = in_data_reg[33:32];

    // Relay logic: F12, K51, K2
    assign main_ok = main_v >= POWER_MIN_DV;
    assign f12     = main_ok && (mach <= MACH_MAX_H);
    assign k51     = main_ok && test_sw;
    assign k2      = (aux_v >= POWER_MIN_DV) && !k51 && ext_relay;
    assign prog    = (!k2 && f12 && !fail) ? prog_t'(sel) : PROG_NONE;

    // Tick / second counting; a program change restarts the cycle
    assign restart    = prog != last_prog_reg;
    assign tick_base  = restart ? '0 : tick_reg;
    assign sec_base   = restart ? '0 : sec_reg;
    assign tick_inc   = tick_base + TICK_W'(1);     // wraps at 65535
    assign roll       = tick_inc > limit_reg;
    assign tick_step  = roll ? '0 : tick_inc;
    assign sec_step   = roll ? sec_base + SEC_W'(1) : sec_base;
    assign cycle_wrap = sec_step > CYCLE_END_SEC;

    always_comb begin
        if (prog == PROG_NONE || cycle_wrap) begin
            tick_next = '0;
            sec_next  = '0;
        end else begin
            tick_next = tick_step;
            sec_next  = sec_step;
        end
        last_prog_next = prog;
    end

    cdhs_windows u_windows (
        .prog (prog),
        .sec  (sec_step),
        .heat (heat)
    );

    assign out_data_next = {7'd0, heat.d, heat.c, heat.b, heat.a,
                            prog, k2, k51, f12};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            tick_reg      <= '0;
            sec_reg       <= '0;
            last_prog_reg <= PROG_NONE;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                tick_reg      <= tick_next;
                sec_reg       <= sec_next;
                last_prog_reg <= last_prog_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- rtl/cdhs_checker.sv -----
`timescale 1ns / 1ps

module cdhs_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic [cdhs_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                               m_tvalid
);
    import cdhs_pkg::*;

    // Reset leaves no word pending
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word present after reset");

    // No program means all heaters off
    a_idle_heaters: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4:3] == PROG_NONE) |-> (m_tdata[8:5] == 4'd0))
        else $error("heater on with no program");

    // A program runs only with F12 on and K2 off
    a_prog_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (!m_tdata[0] || m_tdata[2])) |-> (m_tdata[4:3] == PROG_NONE))
        else $error("program running without heat enable or with block relay");

    // K51 and K2 are mutually exclusive
    a_relay_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
        else $error("test relay and block relay both on");

    // PZ1 never drives the F19 section
    a_pz1_no_b: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4:3] == PROG_PZ1) |-> !m_tdata[6])
        else $error("heater_b on under PZ1");

endmodule

bind cyclic_deicing_heater_sequencer cdhs_checker u_cdhs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid)
);

// ----- bench/cyclic_deicing_heater_sequencer_tb.sv -----
`timescale 1ns / 1ps

module cyclic_deicing_heater_sequencer_tb;
    import cdhs_pkg::*;

    // Tick word as it sits on s_tdata, lowest field last
    typedef struct packed {
        logic [5:0]          pad;
        prog_t               range_sel;
        logic                intake_fail;
        logic                ext_relay;
        logic                test_sw;
        logic [MACH_W-1:0]   mach;
        logic [AUX_V_W-1:0]  aux_v;
        logic [MAIN_V_W-1:0] main_v;
    } tick_word_t;

    // Relay and heater word as it sits on m_tdata
    typedef struct packed {
        logic [6:0] pad;
        heater_t    heaters;
        prog_t      prog;
        logic       block_relay;
        logic       test_relay;
        logic       heat_enable;
    } relay_word_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TICK_W-1:0]    cfg_data = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;

    // Sequencer state mirrored in the bench
    logic [TICK_W-1:0] sec_limit = LIMIT_RESET;
    logic [TICK_W-1:0] tick_cnt = '0;
    logic [SEC_W-1:0]  sec_cnt = '0;
    prog_t             last_prog = PROG_NONE;

    relay_word_t pending_relay_words[$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;

    cyclic_deicing_heater_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic in_span(logic [SEC_W-1:0] s, int lo, int hi);
        return s >= lo && s < hi;
    endfunction

    // One tick through the sequencer: relays, program pick, counters, windows.
    function automatic relay_word_t next_relay_word(tick_word_t t);
        relay_word_t r;
        logic        main_ok;
        prog_t       p;
        r = '0;
        main_ok = t.main_v >= POWER_MIN_DV;
        r.heat_enable = main_ok && t.mach <= MACH_MAX_H;
        r.test_relay  = main_ok && t.test_sw;
        r.block_relay = t.aux_v >= POWER_MIN_DV && !r.test_relay && t.ext_relay;
        p = (!r.block_relay && r.heat_enable && !t.intake_fail) ? t.range_sel : PROG_NONE;
        if (p == PROG_NONE) begin
            tick_cnt = '0;
            sec_cnt  = '0;
        end else begin
            // program change restarts the cycle
            if (p != last_prog) begin
                tick_cnt = '0;
                sec_cnt  = '0;
            end
            tick_cnt = tick_cnt + 1'b1;     // wraps at 16 bits
            if (tick_cnt > sec_limit) begin
                sec_cnt  = sec_cnt + 1'b1;
                tick_cnt = '0;
            end
            case (p)
                PROG_PZ1: begin
                    r.heaters.a = sec_cnt < 20 || in_span(sec_cnt, 120, 140) ||
                                  in_span(sec_cnt, 240, 260) || in_span(sec_cnt, 360, 380);
                    r.heaters.c = sec_cnt > 400 && sec_cnt < 420;
                    r.heaters.d = (sec_cnt > 160 && sec_cnt < 180) ||
                                  (sec_cnt > 440 && sec_cnt < 460);
                end
                PROG_PZ2: begin
                    r.heaters.a = sec_cnt < 20 || in_span(sec_cnt, 120, 140) ||
                                  in_span(sec_cnt, 240, 260) || in_span(sec_cnt, 360, 380);
                    r.heaters.b = in_span(sec_cnt, 40, 60) || in_span(sec_cnt, 280, 300);
                    r.heaters.c = in_span(sec_cnt, 160, 180) || in_span(sec_cnt, 400, 420);
                    r.heaters.d = in_span(sec_cnt, 440, 460);
                end
                default: begin
                    r.heaters.a = sec_cnt < 60 || in_span(sec_cnt, 240, 300);
                    r.heaters.b = in_span(sec_cnt, 120, 180) || in_span(sec_cnt, 360, 420);
                    r.heaters.c = in_span(sec_cnt, 180, 240) || in_span(sec_cnt, 420, 480);
                    r.heaters.d = in_span(sec_cnt, 300, 360);
                end
            endcase
            if (sec_cnt > CYCLE_END_SEC) begin
                sec_cnt  = '0;
                tick_cnt = '0;
            end
        end
        last_prog = p;
        r.prog = p;
        return r;
    endfunction

    function automatic tick_word_t make_tick(int main_v, int aux_v, int mach, int test_sw,
                                             int ext_relay, int intake_fail, prog_t sel);
        tick_word_t w;
        w = '0;
        w.main_v      = MAIN_V_W'(main_v);
        w.aux_v       = AUX_V_W'(aux_v);
        w.mach        = MACH_W'(mach);
        w.test_sw     = test_sw[0];
        w.ext_relay   = ext_relay[0];
        w.intake_fail = intake_fail[0];
        w.range_sel   = sel;
        return w;
    endfunction

    // Random content that still lets program p run: F12 on, K2 off, no failure.
    function automatic tick_word_t active_tick(prog_t p);
        tick_word_t w;
        w = make_tick($urandom_range(1023, 180), 0, $urandom_range(125), 0, 0, 0, p);
        case ($urandom_range(2))
            0: begin
                w.aux_v   = AUX_V_W'($urandom_range(1023));
                w.test_sw = 1'($urandom_range(1));
            end
            1: begin
                w.test_sw   = 1'b1;         // K51 on blocks K2
                w.aux_v     = AUX_V_W'($urandom_range(1023));
                w.ext_relay = 1'($urandom_range(1));
            end
            default: begin
                w.aux_v     = AUX_V_W'($urandom_range(179));
                w.test_sw   = 1'($urandom_range(1));
                w.ext_relay = 1'($urandom_range(1));
            end
        endcase
        return w;
    endfunction

    // Anything goes, weighted toward the power and Mach thresholds.
    function automatic tick_word_t noise_tick();
        tick_word_t w;
        w = make_tick($urandom_range(1023), $urandom_range(1023), $urandom_range(511),
                      $urandom_range(1), $urandom_range(1), $urandom_range(1),
                      prog_t'($urandom_range(3)));
        if ($urandom_range(3) == 0)
            w.main_v = MAIN_V_W'($urandom_range(181, 178));
        if ($urandom_range(3) == 0)
            w.aux_v = AUX_V_W'($urandom_range(181, 178));
        if ($urandom_range(3) == 0)
            w.mach = MACH_W'($urandom_range(126, 124));
        return w;
    endfunction

    task automatic send_tick(input tick_word_t w);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_relay_words.push_back(next_relay_word(w));
    endtask

    // Stop sending and wait until every expected word is back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_relay_words.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [TICK_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sec_limit = value;
    endtask

    task automatic check_field(input string name, input logic [1:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result side: random stalls, or a long forced hold-off when requested
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        relay_word_t want;
        relay_word_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_relay_words.size() == 0) begin
                $error("result word %h with nothing expected", m_tdata);
                fail_count++;
            end else begin
                want = pending_relay_words.pop_front();
                check_field("heat_enable", 2'(want.heat_enable), 2'(got.heat_enable));
                check_field("test_relay", 2'(want.test_relay), 2'(got.test_relay));
                check_field("block_relay", 2'(want.block_relay), 2'(got.block_relay));
                check_field("active_program", want.prog, got.prog);
                check_field("heater_a", 2'(want.heaters.a), 2'(got.heaters.a));
                check_field("heater_b", 2'(want.heaters.b), 2'(got.heaters.b));
                check_field("heater_c", 2'(want.heaters.c), 2'(got.heaters.c));
                check_field("heater_d", 2'(want.heaters.d), 2'(got.heaters.d));
            end
        end
    end

    // Thresholds, relay interlocks and program selection at the reset limit
    task automatic test_relays_and_extremes();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_tick(make_tick(0, 0, 0, 0, 0, 0, PROG_NONE));
        send_tick(make_tick(179, 0, 0, 0, 0, 0, PROG_PZ1));      // main just short
        send_tick(make_tick(180, 0, 125, 0, 0, 0, PROG_PZ1));    // both limits met
        send_tick(make_tick(180, 0, 126, 0, 0, 0, PROG_PZ1));    // Mach too high
        send_tick(make_tick(1023, 1023, 511, 1, 1, 1, PROG_PZ3));
        send_tick(make_tick(180, 180, 0, 0, 1, 0, PROG_PZ2));    // K2 blocks heating
        send_tick(make_tick(180, 179, 0, 0, 1, 0, PROG_PZ2));    // aux short, K2 off
        send_tick(make_tick(1023, 1023, 0, 1, 1, 0, PROG_PZ3));  // K51 overrides K2
        send_tick(make_tick(600, 0, 50, 0, 0, 1, PROG_PZ3));     // intake failure
        send_tick(make_tick(600, 0, 50, 0, 0, 0, PROG_NONE));    // neutral position
        send_tick(make_tick(600, 0, 50, 0, 0, 0, PROG_PZ1));
        send_tick(make_tick(600, 0, 50, 0, 0, 0, PROG_PZ2));
        send_tick(make_tick(600, 0, 50, 0, 0, 0, PROG_PZ3));
        send_tick(make_tick(600, 0, 50, 0, 0, 0, PROG_PZ3));
        drain();
    endtask

    // Limit of zero (one second per tick) and the top limit
    task automatic test_limit_extremes();
        write_limit('0);
        repeat (4) send_tick(active_tick(PROG_PZ3));
        drain();
        write_limit('1);
        repeat (4) send_tick(active_tick(PROG_PZ1));
        drain();
    endtask

    // Full PZ3 cycle through second 480 and the restart, back to back
    task automatic test_pz3_full_cycle();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_limit('0);
        repeat (485) send_tick(active_tick(PROG_PZ3));
        drain();
    endtask

    // PZ1 to its last window with a mostly idle sender; F19 never fires
    task automatic test_pz1_sender_gaps();
        send_idle_pct = 82;
        stall_pct     = 0;
        write_limit('0);
        repeat (462) send_tick(active_tick(PROG_PZ1));
        drain();
    endtask

    // PZ2 with a mostly stalled receiver, opening with a long hold-off so
    // both stages fill and s_tready drops while words keep being offered
    task automatic test_pz2_receiver_stalls();
        send_idle_pct = 0;
        stall_pct     = 82;
        write_limit('0);
        @(posedge aclk);
        hold_left <= 200;
        repeat (130) send_tick(active_tick(PROG_PZ2));
        drain();
    endtask

    // Short runs broken by noise and program changes, at several limits
    task automatic test_mixed_traffic();
        prog_t cur;
        send_idle_pct = 37;
        stall_pct     = 37;
        cur = PROG_PZ1;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       write_limit(16'd1);
                1:       write_limit(TICK_W'($urandom_range(40, 2)));
                default: write_limit(LIMIT_RESET);
            endcase
            repeat (20) begin
                if ($urandom_range(19) == 0)
                    cur = prog_t'($urandom_range(3, 1));
                if ($urandom_range(9) < 7)
                    send_tick(active_tick(cur));
                else
                    send_tick(noise_tick());
            end
            drain();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_relays_and_extremes();
        test_limit_extremes();
        test_pz3_full_cycle();
        test_pz1_sender_gaps();
        test_pz2_receiver_stalls();
        test_mixed_traffic();
        drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
